>>> src/stob_pkg.sv
// ----------------------------------------------------------------------------
// stob_pkg: shared types, constants and weight table
// Geometry, register codes, stage payload structs and the Q8 raised-cosine
// weight table, built at elaboration from a Q30 Taylor cosine.
// ----------------------------------------------------------------------------
package stob_pkg;

    localparam int X_BITS            = 10;
    localparam int Y_BITS            = 10;
    localparam int MAX_WIDTH         = 1 << X_BITS;
    localparam int MAX_HEIGHT        = 1 << Y_BITS;
    localparam int ADDR_W            = X_BITS + Y_BITS - 1;
    localparam int STORE_DEPTH       = MAX_WIDTH * (MAX_HEIGHT / 2);
    localparam int SIZE_W            = 11;
    localparam int STEP_W            = 16;
    localparam int PHASE_W           = 16;
    localparam int CH_W              = 8;
    localparam int PIX_W             = 4 * CH_W;
    localparam int W_W               = 9;
    localparam int WEIGHT_TABLE_BITS = 10;
    localparam int TABLE_LEN         = 1 << WEIGHT_TABLE_BITS;
    localparam int HALF_LEN          = TABLE_LEN / 2;
    localparam int QUARTER_LEN       = TABLE_LEN / 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [W_W-1:0] W_ONE = W_W'(256);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    // pixel modes
    localparam logic [1:0] MODE_GREY   = 2'd0;
    localparam logic [1:0] MODE_RGB    = 2'd1;
    localparam logic [1:0] MODE_RGBA   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP       = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_w;
        logic [SIZE_W-1:0] frame_h;
        logic [X_BITS-1:0] half_w;
        logic [Y_BITS-1:0] half_h;
    } t_geom;

    typedef struct packed {
        logic [X_BITS-1:0] x;
        logic [Y_BITS-1:0] y;
        logic [X_BITS-1:0] qx;
        logic [Y_BITS-1:0] qy;
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  qpix;
    } t_pair;

    typedef struct packed {
        logic [X_BITS-1:0] x;
        logic [Y_BITS-1:0] y;
        logic [PIX_W-1:0]  own;
        logic [PIX_W-1:0]  shifted;
        logic              last;
        logic [W_W-1:0]    w;
    } t_mix;

    typedef logic [W_W-1:0] t_weight_rom [TABLE_LEN];

    // round(128 * (1 - cos(pi/2 * k / QUARTER_LEN)))
    function automatic logic [W_W-1:0] quarter_weight(input logic [WEIGHT_TABLE_BITS-1:0] k);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] h;
        logic [63:0] v;
        logic [63:0] r;
        t = (HALF_PI_Q30 * 64'(k)) / QUARTER_LEN;
        u = (t * t) >> 30;
        h = Q30_ONE - u / 132;
        h = Q30_ONE - ((u * h) >> 30) / 90;
        h = Q30_ONE - ((u * h) >> 30) / 56;
        h = Q30_ONE - ((u * h) >> 30) / 30;
        h = Q30_ONE - ((u * h) >> 30) / 12;
        v = ((u * h) >> 30) / 2;
        r = (v + (64'd1 << 22)) >> 23;
        return r[W_W-1:0];
    endfunction

    function automatic t_weight_rom build_weight_rom();
        t_weight_rom rom;
        int unsigned j;
        for (int unsigned i = 0; i < TABLE_LEN; i++) begin
            j = (i <= HALF_LEN) ? i : TABLE_LEN - i;
            if (j <= QUARTER_LEN) begin
                rom[i] = quarter_weight(WEIGHT_TABLE_BITS'(j));
            end else begin
                rom[i] = W_ONE - quarter_weight(WEIGHT_TABLE_BITS'(HALF_LEN - j));
            end
        end
        return rom;
    endfunction

    localparam t_weight_rom WEIGHT_ROM = build_weight_rom();

endpackage

>>> src/stob_store.sv
// ----------------------------------------------------------------------------
// stob_store: input classification and upper-half frame store
// Drops out-of-frame words, writes upper-half pixels to the store and reads
// the upper-half partner for each lower-half pixel (registered read).
// ----------------------------------------------------------------------------
module stob_store import stob_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [X_BITS-1:0] i_pix_x,
    input  logic [Y_BITS-1:0] i_pix_y,
    input  logic [PIX_W-1:0]  i_pix,
    output logic              o_valid,
    output t_pair             o_pair,
    input  logic              i_ready
);

    logic              in_frame;
    logic              is_lower;
    logic [X_BITS-1:0] qx;
    logic [Y_BITS-1:0] qy;
    logic              s1_ready;
    logic              s2_ready;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic              r_v1;
    logic              r_lower1;
    logic [X_BITS-1:0] r_x1;
    logic [Y_BITS-1:0] r_y1;
    logic [X_BITS-1:0] r_qx1;
    logic [Y_BITS-1:0] r_qy1;
    logic [PIX_W-1:0]  r_pix1;

    logic              r_v2;
    t_pair             r_pair2;

    logic [PIX_W-1:0]  r_mem [STORE_DEPTH];

    assign in_frame = ({1'b0, i_pix_x} < i_geom.frame_w) && ({1'b0, i_pix_y} < i_geom.frame_h);
    assign is_lower = i_pix_y >= i_geom.half_h;
    assign qx       = (i_pix_x < i_geom.half_w) ? i_pix_x + i_geom.half_w
                                                : i_pix_x - i_geom.half_w;
    assign qy       = i_pix_y - i_geom.half_h;

    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;

    // upper half rows fit in Y_BITS-1 bits
    assign wr_addr  = {r_y1[Y_BITS-2:0], r_x1};
    assign rd_addr  = {r_qy1[Y_BITS-2:0], r_qx1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid && in_frame;
            end
            if (s2_ready) begin
                r_v2 <= r_v1 && r_lower1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_lower1 <= is_lower;
            r_x1     <= i_pix_x;
            r_y1     <= i_pix_y;
            r_qx1    <= qx;
            r_qy1    <= qy;
            r_pix1   <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_v1) begin
            if (r_lower1) begin
                r_pair2.x    <= r_x1;
                r_pair2.y    <= r_y1;
                r_pair2.qx   <= r_qx1;
                r_pair2.qy   <= r_qy1;
                r_pair2.pix  <= r_pix1;
                r_pair2.qpix <= r_mem[rd_addr];
            end else begin
                r_mem[wr_addr] <= r_pix1;
            end
        end
    end

    assign o_valid = r_v2;
    assign o_pair  = r_pair2;

endmodule

>>> src/stob_pair.sv
// ----------------------------------------------------------------------------
// stob_pair: pair split and weight lookup
// Splits each lower-half pair into the partner result and the own result,
// computes column and row phases, then looks up and maxes the two weights.
// ----------------------------------------------------------------------------
module stob_pair import stob_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [STEP_W-1:0] i_x_step,
    input  logic [STEP_W-1:0] i_y_step,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pair             i_pair,
    output logic              o_valid,
    output t_mix              o_mix,
    input  logic              i_ready
);

    localparam int PROD_X_W = X_BITS + STEP_W;
    localparam int PROD_Y_W = Y_BITS + STEP_W;

    t_mix                   sel;
    t_mix                   n_mix5;
    logic [PROD_X_W-1:0]    prod_x;
    logic [PROD_Y_W-1:0]    prod_y;
    logic [W_W-1:0]         wx;
    logic [W_W-1:0]         wy;
    logic                   s3_ready;
    logic                   s4_ready;
    logic                   s5_ready;

    logic                   r_v3;
    logic                   r_ph;
    t_pair                  r_pair3;
    logic                   r_v4;
    t_mix                   r_mix4;
    logic [PHASE_W-1:0]     r_px4;
    logic [PHASE_W-1:0]     r_py4;
    logic                   r_v5;
    t_mix                   r_mix5;

    always_comb begin
        sel.w = '0;
        if (!r_ph) begin
            sel.x       = r_pair3.qx;
            sel.y       = r_pair3.qy;
            sel.own     = r_pair3.qpix;
            sel.shifted = r_pair3.pix;
            sel.last    = 1'b0;
        end else begin
            sel.x       = r_pair3.x;
            sel.y       = r_pair3.y;
            sel.own     = r_pair3.pix;
            sel.shifted = r_pair3.qpix;
            sel.last    = 1'b1;
        end
    end

    assign prod_x = PROD_X_W'(sel.x) * PROD_X_W'(i_x_step);
    assign prod_y = PROD_Y_W'(sel.y) * PROD_Y_W'(i_y_step);

    assign wx = WEIGHT_ROM[r_px4[PHASE_W-1 -: WEIGHT_TABLE_BITS]];
    assign wy = WEIGHT_ROM[r_py4[PHASE_W-1 -: WEIGHT_TABLE_BITS]];

    always_comb begin
        n_mix5   = r_mix4;
        n_mix5.w = (wx > wy) ? wx : wy;
    end

    assign s5_ready = !r_v5 || i_ready;
    assign s4_ready = !r_v4 || s5_ready;
    assign s3_ready = !r_v3 || (r_ph && s4_ready);
    assign o_ready  = s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_ph <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s3_ready) begin
                r_v3 <= i_valid;
            end
            if (r_v3 && s4_ready) begin
                r_ph <= !r_ph;
            end
            if (s4_ready) begin
                r_v4 <= r_v3;
            end
            if (s5_ready) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && i_valid) begin
            r_pair3 <= i_pair;
        end
        if (s4_ready && r_v3) begin
            r_mix4 <= sel;
            r_px4  <= prod_x[PHASE_W-1:0];
            r_py4  <= prod_y[PHASE_W-1:0];
        end
        if (s5_ready && r_v4) begin
            r_mix5 <= n_mix5;
        end
    end

    assign o_valid = r_v5;
    assign o_mix   = r_mix5;

endmodule

>>> src/stob_blend.sv
// ----------------------------------------------------------------------------
// stob_blend: channel blend and output register
// Mixes shifted and own pixels in channels 0-2 (RGB, RGBA) with the Q8 weight,
// applies the pixel mode and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module stob_blend import stob_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_mode,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_mix              i_mix,
    output logic              o_valid,
    output logic [X_BITS-1:0] o_out_x,
    output logic [Y_BITS-1:0] o_out_y,
    output logic [CH_W-1:0]   o_res0,
    output logic [CH_W-1:0]   o_res1,
    output logic [CH_W-1:0]   o_res2,
    output logic [CH_W-1:0]   o_res3,
    output logic              o_run_last,
    input  logic              i_ready
);

    localparam int ACC_W = CH_W + W_W;

    function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] s,
                                            input logic [CH_W-1:0] o,
                                            input logic [W_W-1:0]  w);
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(s) * ACC_W'(W_ONE - w) + ACC_W'(o) * ACC_W'(w);
        return acc[CH_W +: CH_W];
    endfunction

    logic            s6_ready;
    logic [CH_W-1:0] n_res0;
    logic [CH_W-1:0] n_res1;
    logic [CH_W-1:0] n_res2;
    logic [CH_W-1:0] n_res3;

    logic              r_v6;
    logic [X_BITS-1:0] r_x;
    logic [Y_BITS-1:0] r_y;
    logic [CH_W-1:0]   r_res0;
    logic [CH_W-1:0]   r_res1;
    logic [CH_W-1:0]   r_res2;
    logic [CH_W-1:0]   r_res3;
    logic              r_last;

    always_comb begin
        unique case (i_mode)
            MODE_RGB, MODE_RGBA: begin
                n_res0 = mix(i_mix.shifted[0*CH_W +: CH_W], i_mix.own[0*CH_W +: CH_W], i_mix.w);
                n_res1 = mix(i_mix.shifted[1*CH_W +: CH_W], i_mix.own[1*CH_W +: CH_W], i_mix.w);
                n_res2 = mix(i_mix.shifted[2*CH_W +: CH_W], i_mix.own[2*CH_W +: CH_W], i_mix.w);
                n_res3 = (i_mode == MODE_RGBA) ? i_mix.own[3*CH_W +: CH_W] : '0;
            end
            default: begin
                n_res0 = i_mix.own[0 +: CH_W];
                n_res1 = '0;
                n_res2 = '0;
                n_res3 = '0;
            end
        endcase
    end

    assign s6_ready = !r_v6 || i_ready;
    assign o_ready  = s6_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (s6_ready) begin
            r_v6 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s6_ready && i_valid) begin
            r_x    <= i_mix.x;
            r_y    <= i_mix.y;
            r_res0 <= n_res0;
            r_res1 <= n_res1;
            r_res2 <= n_res2;
            r_res3 <= n_res3;
            r_last <= i_mix.last;
        end
    end

    assign o_valid    = r_v6;
    assign o_out_x    = r_x;
    assign o_out_y    = r_y;
    assign o_res0     = r_res0;
    assign o_res1     = r_res1;
    assign o_res2     = r_res2;
    assign o_res3     = r_res3;
    assign o_run_last = r_last;

endmodule

>>> src/seamless_tile_offset_blend.sv
// ----------------------------------------------------------------------------
// seamless_tile_offset_blend: half-offset cosine blend for tileable images
// Pixels enter in raster order on i_valid/o_ready with position and four
// channels. Upper-half pixels are written to an on-chip frame store and give
// no result. Each lower-half pixel gives two result words on o_valid/i_ready:
// first its upper-half partner position (run_last 0), then its own position
// (run_last 1). Pixels outside the configured frame are dropped.
// Throughput: one result word per cycle unless the receiver stalls; a
// lower-half pixel holds the pair stage until both of its words move on.
// Registers are written on i_cfg_valid/o_cfg_ready (always ready); the user
// must write them only while the block is empty (not enforced by the block).
// Reset clears all valid bits and loads register defaults (256 x 256, RGB,
// phase steps 256). The frame store is not cleared: a frame's upper half must
// be sent before its lower half.
// A stalled receiver holds the output word; the stall backs up stage by stage
// to o_ready without loss or repeat.
// ----------------------------------------------------------------------------
module seamless_tile_offset_blend import stob_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [X_BITS-1:0]     i_pix_x,
    input  logic [Y_BITS-1:0]     i_pix_y,
    input  logic [CH_W-1:0]       i_chan0,
    input  logic [CH_W-1:0]       i_chan1,
    input  logic [CH_W-1:0]       i_chan2,
    input  logic [CH_W-1:0]       i_chan3,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [X_BITS-1:0]     o_out_x,
    output logic [Y_BITS-1:0]     o_out_y,
    output logic [CH_W-1:0]       o_res0,
    output logic [CH_W-1:0]       o_res1,
    output logic [CH_W-1:0]       o_res2,
    output logic [CH_W-1:0]       o_res3,
    output logic                  o_run_last
);

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (r < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end
        if (r > maxv) begin
            r = maxv;
        end
        return {r[SIZE_W-1:1], 1'b0};
    endfunction

    logic [SIZE_W-1:0] r_frame_w;
    logic [SIZE_W-1:0] r_frame_h;
    logic [1:0]        r_mode;
    logic [STEP_W-1:0] r_x_step;
    logic [STEP_W-1:0] r_y_step;

    t_geom  geom;
    logic   st_valid;
    logic   st_ready;
    t_pair  st_pair;
    logic   pr_valid;
    logic   pr_ready;
    t_mix   pr_mix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= SIZE_W'(256);
            r_frame_h <= SIZE_W'(256);
            r_mode    <= MODE_RGB;
            r_x_step  <= STEP_W'(256);
            r_y_step  <= STEP_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_w <= eff_size(i_cfg_data[SIZE_W-1:0],
                                                        SIZE_W'(MAX_WIDTH));
                CFG_FRAME_HEIGHT: r_frame_h <= eff_size(i_cfg_data[SIZE_W-1:0],
                                                        SIZE_W'(MAX_HEIGHT));
                CFG_PIXEL_MODE:   r_mode    <= i_cfg_data[1:0];
                CFG_X_STEP:       r_x_step  <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:       r_y_step  <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign geom.frame_w = r_frame_w;
    assign geom.frame_h = r_frame_h;
    assign geom.half_w  = r_frame_w[SIZE_W-1:1];
    assign geom.half_h  = r_frame_h[SIZE_W-1:1];

    stob_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix_x (i_pix_x),
        .i_pix_y (i_pix_y),
        .i_pix   ({i_chan3, i_chan2, i_chan1, i_chan0}),
        .o_valid (st_valid),
        .o_pair  (st_pair),
        .i_ready (st_ready)
    );

    stob_pair u_pair (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_x_step (r_x_step),
        .i_y_step (r_y_step),
        .i_valid  (st_valid),
        .o_ready  (st_ready),
        .i_pair   (st_pair),
        .o_valid  (pr_valid),
        .o_mix    (pr_mix),
        .i_ready  (pr_ready)
    );

    stob_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_valid    (pr_valid),
        .o_ready    (pr_ready),
        .i_mix      (pr_mix),
        .o_valid    (o_valid),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_res0     (o_res0),
        .o_res1     (o_res1),
        .o_res2     (o_res2),
        .o_res3     (o_res3),
        .o_run_last (o_run_last),
        .i_ready    (i_ready)
    );

    a_first_in_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_run_last |-> o_out_y < geom.half_h)
        else $error("first word of a pair not in upper half");

    a_last_in_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_last |-> {1'b0, o_out_y} >= {1'b0, geom.half_h}
                                  && {1'b0, o_out_y} < r_frame_h)
        else $error("second word of a pair not in lower half");

    a_x_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_out_x} < r_frame_w)
        else $error("result column outside frame");

    a_grey_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_mode == MODE_GREY || r_mode == MODE_UNUSED)
            |-> o_res1 == '0 && o_res2 == '0 && o_res3 == '0)
        else $error("grey result carries color channels");

endmodule
